/* hdl/mep_pkg.sv */
// Package for the escape-time pixel unit: widths, reset values, register
// indexes, sequencer states and the saturation helper. No dependencies.
`timescale 1ns / 1ps

package mep_pkg;

    localparam int unsigned MAX_ITERATIONS_DEF = 200;

    localparam int unsigned COORD_W   = 10;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned STEP_W    = 25;
    localparam int unsigned ITER_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned FRAC_BITS = 24;
    localparam int unsigned PROD_W    = 2 * DATA_W;
    localparam int unsigned Q_W       = PROD_W - FRAC_BITS;
    localparam int unsigned SUM_W     = 42;

    localparam logic signed [DATA_W-1:0] START_X_RST = -32'sd36909875;
    localparam logic signed [DATA_W-1:0] START_Y_RST = -32'sd20132659;
    localparam logic [STEP_W-1:0]        STEP_RST    = 25'd67109;

    localparam logic signed [SUM_W-1:0] ESC_LIMIT = 42'sd1677721600;
    localparam logic signed [SUM_W-1:0] SAT_MAX   = 42'sd2147483647;
    localparam logic signed [SUM_W-1:0] SAT_MIN   = -42'sd2147483648;

    localparam logic [DATA_W-1:0] COLOR_BASE = 32'hCCCCCCCC;
    localparam logic [DATA_W-1:0] COLOR_IN   = 32'h00000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X,
        REG_START_Y,
        REG_STEP_SIZE
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CX,
        ST_CY,
        ST_CS,
        ST_XX,
        ST_YY,
        ST_XY,
        ST_UPD,
        ST_DONE
    } t_state;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[DATA_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hdl/mep_if.sv */
// Channel interfaces of the escape-time pixel unit: pixel request, result
// and configuration write. Depends on mep_pkg.
`timescale 1ns / 1ps

interface mep_req_if;
    import mep_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    modport source (output valid, output row, output col, input ready);
    modport sink   (input valid, input row, input col, output ready);
endinterface

interface mep_res_if;
    import mep_pkg::*;
    logic              valid;
    logic              ready;
    logic [ITER_W-1:0] iterations;
    logic              in_set;
    logic [DATA_W-1:0] pixel_color;
    modport source (output valid, output iterations, output in_set, output pixel_color,
                    input ready);
    modport sink   (input valid, input iterations, input in_set, input pixel_color,
                    output ready);
endinterface

interface mep_cfg_if;
    import mep_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/mandelbrot_escape_pixel_unit.sv */
// Escape-time pixel unit: one shared 32x32 signed multiplier under a sequencer.
// Per request it forms c_x and c_y from the products col*step and row*step,
// then per iterate the products x*x, y*y and x*y and an update; iterates tested
// are iterations + 1 on escape, else MAX_ITERATIONS. A finished result may wait
// in the output register while the next request is taken. Synchronous active-low
// reset restores start_x, start_y, step_size to their defaults and idles.
// Depends on mep_pkg and mep_if.
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_unit #(
    parameter int unsigned MAX_ITERATIONS = mep_pkg::MAX_ITERATIONS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mep_cfg_if.sink        i_cfg,
    mep_req_if.sink        i_req,
    mep_res_if.source      o_res
);
    import mep_pkg::*;

    localparam int unsigned CW = $clog2(MAX_ITERATIONS + 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(MAX_ITERATIONS - 1);
    localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_ITERATIONS);

    t_state r_state, n_state;

    logic signed [DATA_W-1:0] r_start_x, r_start_y;
    logic [STEP_W-1:0]        r_step;
    logic [COORD_W-1:0]       r_row, r_col;
    logic signed [DATA_W-1:0] r_cx, r_cy, r_x, r_y;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [Q_W-1:0]    r_x2, r_y2;
    logic                     r_esc;
    logic [CW-1:0]            r_count;

    logic                     r_out_valid;
    logic [ITER_W-1:0]        r_iter;
    logic                     r_inset;
    logic [DATA_W-1:0]        r_color;

    logic                     w_req_ready;
    logic                     w_out_load;
    logic signed [DATA_W-1:0] w_op_a, w_op_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [Q_W-1:0]    w_q;
    logic signed [SUM_W-1:0]  w_c_sum, w_mag, w_nx, w_ny;
    logic [DATA_W-1:0]        w_count32;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = w_req_ready;

    // shared multiplier and fixed-point views
    assign w_prod  = PROD_W'(w_op_a) * PROD_W'(w_op_b);
    assign w_q     = r_prod[PROD_W-1:FRAC_BITS];
    assign w_c_sum = SUM_W'(r_prod[SUM_W-2:0])
                   + SUM_W'((r_state == ST_CY) ? r_start_x : r_start_y);
    assign w_mag   = SUM_W'(r_x2) + SUM_W'(w_q);
    assign w_nx    = SUM_W'(r_x2) - SUM_W'(r_y2) + SUM_W'(r_cx);
    assign w_ny    = SUM_W'(w_q) + SUM_W'(w_q) + SUM_W'(r_cy);
    assign w_count32 = DATA_W'(r_count);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_req.valid) n_state = ST_CX;
            ST_CX:   n_state = ST_CY;
            ST_CY:   n_state = ST_CS;
            ST_CS:   n_state = ST_XX;
            ST_XX:   n_state = ST_YY;
            ST_YY:   n_state = ST_XY;
            ST_XY:   n_state = ST_UPD;
            ST_UPD: begin
                if (r_esc || (r_count == CNT_LAST)) n_state = ST_DONE;
                else n_state = ST_XX;
            end
            ST_DONE: if (w_out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_req_ready = 1'b0;
        w_out_load  = 1'b0;
        w_op_a      = '0;
        w_op_b      = '0;
        unique case (r_state)
            ST_IDLE: w_req_ready = 1'b1;
            ST_CX: begin
                w_op_a = DATA_W'(r_col);
                w_op_b = DATA_W'(r_step);
            end
            ST_CY: begin
                w_op_a = DATA_W'(r_row);
                w_op_b = DATA_W'(r_step);
            end
            ST_XX: begin
                w_op_a = r_x;
                w_op_b = r_x;
            end
            ST_YY: begin
                w_op_a = r_y;
                w_op_b = r_y;
            end
            ST_XY: begin
                w_op_a = r_x;
                w_op_b = r_y;
            end
            ST_DONE: w_out_load = !r_out_valid || o_res.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start_x   <= START_X_RST;
            r_start_y   <= START_Y_RST;
            r_step      <= STEP_RST;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_START_X:   r_start_x <= i_cfg.data;
                    REG_START_Y:   r_start_y <= i_cfg.data;
                    REG_STEP_SIZE: r_step    <= i_cfg.data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (w_out_load) r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
            if (w_req_ready && i_req.valid) r_count <= '0;
            else if (r_state == ST_UPD && !r_esc) r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_row <= i_req.row;
                r_col <= i_req.col;
                r_x   <= '0;
                r_y   <= '0;
            end
            ST_CX: r_prod <= w_prod;
            ST_CY: begin
                r_prod <= w_prod;
                r_cx   <= sat32(w_c_sum);
            end
            ST_CS: r_cy <= sat32(w_c_sum);
            ST_XX: r_prod <= w_prod;
            ST_YY: begin
                r_prod <= w_prod;
                r_x2   <= w_q;
            end
            ST_XY: begin
                r_prod <= w_prod;
                r_y2   <= w_q;
                r_esc  <= w_mag > ESC_LIMIT;
            end
            ST_UPD: begin
                if (!r_esc) begin
                    r_x <= sat32(w_nx);
                    r_y <= sat32(w_ny);
                end
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_iter  <= w_count32[ITER_W-1:0];
            r_inset <= (r_count == CNT_MAX);
            r_color <= (r_count == CNT_MAX) ? COLOR_IN : COLOR_BASE - (w_count32 << 4);
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.iterations  = r_iter;
    assign o_res.in_set      = r_inset;
    assign o_res.pixel_color = r_color;

    a_inset_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_inset) |-> (r_color == COLOR_IN))
        else $error("in-set result with nonzero color");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("iteration count above maximum");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == ST_CX))
        else $error("request accepted without starting");

    a_escape_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD && r_esc) |=> ($stable(r_count) && r_state == ST_DONE))
        else $error("escaped iterate was counted");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || o_res.ready))
        else $error("result register overwritten while held");

endmodule
